[rtl/lzbwd_pkg.sv]
// Shared types and constants of the bit-window LZ77 decompressor.
// Used by the token channel interface, the controller, the datapath and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lzbwd_pkg;

  // Field widths of the token and head register
  localparam int unsigned POS_W  = 13;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned HEAD_W = 13;

  // Defaults of the top-level parameters
  localparam int unsigned WINDOW_BITS_DEF = 1024 * 8;
  localparam int unsigned MAX_COPY_DEF    = 64;

  // Head register value after reset
  localparam logic [HEAD_W-1:0] HEAD_RST = 13'd8128;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_tok;   // capture an accepted token
    logic copy_rd;    // move the window, read the copy source
    logic copy_wr;    // write the copied bit at the head
    logic lit_wr;     // move the window, write the literal at the head
    logic emit_rd;    // read the next bit of the run
    logic emit_cap;   // load the result register
    logic emit_next;  // result transaction done, step to the next bit
    logic sweep_en;   // clearing sweep may use the write port
  } lzbwd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic copy_done;   // all copy steps of the token are done
    logic emit_last;   // the result register holds the final bit
    logic sweep_busy;  // window clearing still in progress
  } lzbwd_sts_t;

endpackage

`default_nettype wire

[rtl/lzbwd_tok_if.sv]
// Token channel: valid/ready handshake carrying one LZ77 token.
// Depends on lzbwd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lzbwd_tok_if import lzbwd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] copy_position;
  logic [LEN_W-1:0] copy_length;
  logic             literal_bit;

  modport source (
    output valid,
    output copy_position,
    output copy_length,
    output literal_bit,
    input  ready
  );

  modport sink (
    input  valid,
    input  copy_position,
    input  copy_length,
    input  literal_bit,
    output ready
  );

endinterface

`default_nettype wire

[rtl/lzbwd_bit_if.sv]
// Result channel: valid/ready handshake carrying one decompressed bit.
// Depends on nothing beyond the handshake itself.
`timescale 1ns / 1ps
`default_nettype none

interface lzbwd_bit_if;

  logic valid;
  logic ready;
  logic out_bit;
  logic last;

  modport source (
    output valid,
    output out_bit,
    output last,
    input  ready
  );

  modport sink (
    input  valid,
    input  out_bit,
    input  last,
    output ready
  );

endinterface

`default_nettype wire

[rtl/lz77_bit_window_decompressor_top.sv]
// After acceptance a token with copy length L (clamped to MAX_COPY-1) runs L copy steps,
// then the literal write, as window updates; each bit of the run is then read, captured
// and offered, and the next bit is read only after the previous result transaction.
// The rate is set by the single window RAM and its registered read in each copy step.
// Reset clears the whole window by a sweep; a head write sweeps from just above the
// lower of old and new head up. No token is accepted during a sweep.
`timescale 1ns / 1ps
`default_nettype none

module lz77_bit_window_decompressor_top import lzbwd_pkg::*; #(
  parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF,
  parameter int unsigned MAX_COPY    = MAX_COPY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lzbwd_tok_if.sink              tok_i,
  lzbwd_bit_if.source            res_o,
  input  wire logic              cfg_we_i,
  input  wire logic [HEAD_W-1:0] cfg_wdata_i
);

  lzbwd_cmd_t cmd;
  lzbwd_sts_t sts;

  // Sequencer
  lzbwd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tok_i.valid),
    .in_ready_o  (tok_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Window and token datapath
  lzbwd_dp #(
    .WINDOW_BITS (WINDOW_BITS),
    .MAX_COPY    (MAX_COPY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pos_i       (tok_i.copy_position),
    .len_i       (tok_i.copy_length),
    .lit_i       (tok_i.literal_bit),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_bit_o   (res_o.out_bit),
    .last_o      (res_o.last)
  );

endmodule

`default_nettype wire

[rtl/lzbwd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module lzbwd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/lzbwd_ctrl.sv]
// Controller state machine: sequences copy steps, the literal write and the
// emission of the result bits. Depends on lzbwd_pkg for command/status types.
`timescale 1ns / 1ps
`default_nettype none

module lzbwd_ctrl import lzbwd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire lzbwd_sts_t sts_i,
  output lzbwd_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_COPY_RD  = 6'b000010,
    S_COPY_WR  = 6'b000100,
    S_EMIT_RD  = 6'b001000,
    S_EMIT_CAP = 6'b010000,
    S_EMIT_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;
  logic   out_fire;

  assign in_ready_o  = (state_q == S_IDLE) && !sts_i.sweep_busy;
  assign out_valid_o = (state_q == S_EMIT_OUT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.sweep_en = 1'b1;
        if (in_fire) begin
          cmd_o.load_tok = 1'b1;
          state_d        = S_COPY_RD;
        end
      end
      S_COPY_RD: begin
        if (sts_i.copy_done) begin
          cmd_o.lit_wr = 1'b1;
          state_d      = S_EMIT_RD;
        end else begin
          cmd_o.copy_rd = 1'b1;
          state_d       = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        state_d       = S_COPY_RD;
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EMIT_CAP;
      end
      S_EMIT_CAP: begin
        cmd_o.emit_cap = 1'b1;
        state_d        = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_fire) begin
          cmd_o.emit_next = 1'b1;
          state_d         = sts_i.emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted token always starts with the copy/literal decision
  a_accept_starts_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_COPY_RD)
    else $error("token accepted without entering the copy phase");

  // The final result transaction of a token returns to idle
  a_last_ends_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && sts_i.emit_last) |=> state_q == S_IDLE)
    else $error("final bit delivered but controller not idle");

endmodule

`default_nettype wire

[rtl/lzbwd_dp.sv]
// Datapath: head register, ring-addressed bit window in RAM, token registers,
// clearing sweep and result register. Depends on lzbwd_pkg and lzbwd_ram.
`timescale 1ns / 1ps
`default_nettype none

module lzbwd_dp import lzbwd_pkg::*; #(
  parameter int unsigned WINDOW_BITS = WINDOW_BITS_DEF,
  parameter int unsigned MAX_COPY    = MAX_COPY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lzbwd_cmd_t        cmd_i,
  output lzbwd_sts_t             sts_o,
  input  wire logic [POS_W-1:0]  pos_i,
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic              lit_i,
  input  wire logic              cfg_we_i,
  input  wire logic [HEAD_W-1:0] cfg_wdata_i,
  output logic                   out_bit_o,
  output logic                   last_o
);

  localparam int unsigned AW = $clog2(WINDOW_BITS);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = ((AW > HEAD_W) ? AW : HEAD_W) + 1;
  localparam logic [PW-1:0] WIN_P   = PW'(WINDOW_BITS);
  localparam logic [AW-1:0] WIN_TOP = AW'(WINDOW_BITS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_COPY - 1);

  // Window index to RAM address: rotate by the base pointer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [AW-1:0] k);
    logic [PW-1:0] s;
    s = {1'b0, b} + {1'b0, k};
    if (s >= WIN_P) begin
      s = s - WIN_P;
    end
    return s[AW-1:0];
  endfunction

  // Head index limited to the top of the window
  function automatic logic [AW-1:0] head_eff(input logic [HEAD_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    if (e > CW'(WINDOW_BITS - 1)) begin
      return WIN_TOP;
    end
    return e[AW-1:0];
  endfunction

  logic [HEAD_W-1:0] head_q;
  logic [AW-1:0]     base_q, base_d, base_inc;
  logic [PW-1:0]     sw_q, sw_d, sw_new;
  logic [AW-1:0]     h_new, sw_from;
  logic [POS_W-1:0]  pos_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              lit_q;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              pos_ok_q;
  logic              back_ok_q, back_ok;
  logic              out_bit_q;
  logic              last_q;
  logic [AW-1:0]     h;
  logic [CW-1:0]     pos_ext, back_ext, run_idx;
  logic              sweep_busy;
  logic              ram_we, ram_re, ram_wdata, ram_rdata;
  logic [AW-1:0]     ram_waddr, ram_raddr;

  assign h          = head_eff(head_q);
  assign base_inc   = (base_q == WIN_TOP) ? '0 : base_q + 1'b1;
  assign sweep_busy = (sw_q != WIN_P);
  assign pos_ext    = CW'(pos_q);
  assign back_ext   = CW'(cnt_q);
  assign back_ok    = (back_ext <= CW'(h));
  assign run_idx    = CW'(h) - back_ext;
  // Ring moves leave dropped bits above the old head, so clear from the lower head up
  assign h_new      = head_eff(cfg_wdata_i);
  assign sw_from    = (h_new < h) ? h_new : h;
  assign sw_new     = {1'b0, sw_from} + 1'b1;
  assign len_d      = (len_i > LEN_MAX) ? LEN_MAX : len_i;

  // Head register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HEAD_RST;
    end else if (cfg_we_i) begin
      head_q <= cfg_wdata_i;
    end
  end

  // Clearing sweep: restart from just above the lower of old and new head on a head write
  always_comb begin
    sw_d = sw_q;
    if (cfg_we_i) begin
      sw_d = (sw_new < sw_q) ? sw_new : sw_q;
    end else if (sweep_busy && cmd_i.sweep_en) begin
      sw_d = sw_q + 1'b1;
    end
  end

  // Base pointer: advance on every window move
  always_comb begin
    base_d = base_q;
    if (cmd_i.copy_rd || cmd_i.lit_wr) begin
      base_d = base_inc;
    end
  end

  // Step counter: copies done, then bits still to emit
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load_tok) begin
      cnt_d = '0;
    end else if (cmd_i.copy_wr) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.lit_wr) begin
      cnt_d = len_q;
    end else if (cmd_i.emit_next && (cnt_q != '0)) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= '0;
      base_q <= '0;
      cnt_q  <= '0;
      len_q  <= '0;
    end else begin
      sw_q   <= sw_d;
      base_q <= base_d;
      cnt_q  <= cnt_d;
      if (cmd_i.load_tok) begin
        len_q <= len_d;
      end
    end
  end

  // Token and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      pos_q    <= pos_i;
      lit_q    <= lit_i;
      pos_ok_q <= (CW'(pos_i) < CW'(h));
    end
    if (cmd_i.emit_rd) begin
      back_ok_q <= back_ok;
    end
    if (cmd_i.emit_cap) begin
      out_bit_q <= back_ok_q & ram_rdata;
      last_q    <= (cnt_q == '0);
    end
  end

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(base_q, h);
    ram_wdata = 1'b0;
    if (cmd_i.copy_wr) begin
      ram_we    = 1'b1;
      ram_wdata = pos_ok_q & ram_rdata;
    end else if (cmd_i.lit_wr) begin
      ram_we    = 1'b1;
      ram_waddr = phys(base_inc, h);
      ram_wdata = lit_q;
    end else if (sweep_busy && cmd_i.sweep_en) begin
      ram_we    = 1'b1;
      ram_waddr = phys(base_q, sw_q[AW-1:0]);
    end
  end

  assign ram_re    = cmd_i.copy_rd || cmd_i.emit_rd;
  assign ram_raddr = cmd_i.copy_rd ? phys(base_inc, pos_ext[AW-1:0])
                                   : phys(base_q, run_idx[AW-1:0]);

  lzbwd_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.copy_done  = (cnt_q == len_q);
  assign sts_o.emit_last  = (cnt_q == '0);
  assign sts_o.sweep_busy = sweep_busy;
  assign out_bit_o        = out_bit_q;
  assign last_o           = last_q;

  // Base pointer stays inside the ring
  a_base_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= WIN_TOP)
    else $error("window base pointer left the ring");

  // Sweep pointer never runs past the window
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_q <= WIN_P)
    else $error("clearing sweep ran past the window");

  // Step counter never exceeds the clamped copy length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= len_q && len_q <= LEN_MAX)
    else $error("step counter beyond copy length");

endmodule

`default_nettype wire
